### rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the address text serializer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/ipv6ts_pkg.sv
// Shared types, constants and functions of the IPv6 address text serializer.
`default_nettype none

package ipv6ts_pkg;

  localparam int unsigned NUM_PIECES = 8;
  localparam int unsigned PIECE_W    = 16;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned QDEPTH     = 2;

  localparam logic [CHAR_W-1:0] CHAR_COLON    = 7'h3A;
  localparam logic [CHAR_W-1:0] CHAR_ZERO     = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A_OFFSET = 7'h57;

  // One address, classified: the digits and the colon that each piece emits.
  typedef struct packed {
    logic [NUM_PIECES-1:0][PIECE_W-1:0] piece;
    logic [NUM_PIECES-1:0][2:0]         ndig;
    logic [NUM_PIECES-1:0]              col;
    logic [NUM_PIECES-1:0]              busy;
    logic                               lead;
  } desc_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] ext;
    ext = {3'b000, nib};
    if (nib < 4'd10) begin
      return CHAR_ZERO + ext;
    end else begin
      return CHAR_A_OFFSET + ext;
    end
  endfunction

endpackage

`default_nettype wire

### rtl/ipv6ts_if.sv
// Channel interfaces: the address input and the character output.
`default_nettype none

interface ipv6ts_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] piece_0;
  logic [15:0] piece_1;
  logic [15:0] piece_2;
  logic [15:0] piece_3;
  logic [15:0] piece_4;
  logic [15:0] piece_5;
  logic [15:0] piece_6;
  logic [15:0] piece_7;

  modport source(output valid, output piece_0, output piece_1, output piece_2,
                 output piece_3, output piece_4, output piece_5, output piece_6,
                 output piece_7, input ready);
  modport sink(input valid, input piece_0, input piece_1, input piece_2,
               input piece_3, input piece_4, input piece_5, input piece_6,
               input piece_7, output ready);
endinterface

interface ipv6ts_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] character;
  logic       last;

  modport source(output valid, output character, output last, input ready);
  modport sink(input valid, input character, input last, output ready);
endinterface

`default_nettype wire

### rtl/ipv6_text_serializer.sv
// IPv6 address text serializer: one address in, its compressed text out one character per word.
// Each input word is an address as eight 16-bit pieces; the output is its lowercase text form
// with the first longest run of two or more zero pieces written as a double colon, one ASCII
// character per output word and last set on the final character. An address of n characters
// (2 to 39) is written out one character at a time, so a stream of addresses leaves at one
// character per cycle while the output is ready; the emitter's single-character output register
// sets that rate. The front end classifies an address in the cycle it is accepted and parks it
// in a two-entry queue, so one further address is taken while one is being written out.
// On an idle block an address is queued, then its first character enters the output register.
`default_nettype none

module ipv6_text_serializer (
  input  wire logic     clk,
  input  wire logic     rst_n,
  ipv6ts_in_if.sink     in_word,
  ipv6ts_out_if.source  out_word
);

  ipv6ts_pkg::desc_t push_desc;
  logic              push_valid;
  logic              push_ready;
  ipv6ts_pkg::desc_t head;
  logic              head_valid;
  logic              head_pop;

  ipv6ts_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_word),
    .push_desc  (push_desc),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  ipv6ts_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wdata  (push_desc),
    .wvalid (push_valid),
    .wready (push_ready),
    .rdata  (head),
    .rvalid (head_valid),
    .rpop   (head_pop)
  );

  ipv6ts_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .out_word   (out_word)
  );

endmodule

`default_nettype wire

### rtl/ipv6ts_front.sv
// Front end: finds the compressed zero run and classifies every piece of an address.
`default_nettype none
`include "assert_macros.svh"

module ipv6ts_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  ipv6ts_in_if.sink         in_word,
  output ipv6ts_pkg::desc_t push_desc,
  output logic              push_valid,
  input  wire logic         push_ready
);

  logic [ipv6ts_pkg::NUM_PIECES-1:0][ipv6ts_pkg::PIECE_W-1:0] pieces;
  logic [ipv6ts_pkg::NUM_PIECES-1:0] zero;
  logic [3:0] run_len;
  logic [3:0] best_len;
  logic [2:0] run_start;
  logic [2:0] best_start;
  logic       comp;
  logic [3:0] run_end;

  assign pieces[0] = in_word.piece_0;
  assign pieces[1] = in_word.piece_1;
  assign pieces[2] = in_word.piece_2;
  assign pieces[3] = in_word.piece_3;
  assign pieces[4] = in_word.piece_4;
  assign pieces[5] = in_word.piece_5;
  assign pieces[6] = in_word.piece_6;
  assign pieces[7] = in_word.piece_7;

  // Scan for the first longest run of zero pieces; a later run must be strictly longer.
  always_comb begin
    run_len    = 4'd0;
    best_len   = 4'd0;
    run_start  = 3'd0;
    best_start = 3'd0;
    for (int i = 0; i < ipv6ts_pkg::NUM_PIECES; i++) begin
      zero[i] = (pieces[i] == '0);
      if (zero[i]) begin
        if (run_len == 4'd0) begin
          run_start = 3'(i);
        end
        run_len = run_len + 4'd1;
        if (run_len > best_len) begin
          best_len   = run_len;
          best_start = run_start;
        end
      end else begin
        run_len = 4'd0;
      end
    end
  end

  assign comp    = (best_len >= 4'd2);
  assign run_end = {1'b0, best_start} + best_len;

  always_comb begin
    logic       in_run;
    logic [2:0] digits;
    for (int i = 0; i < ipv6ts_pkg::NUM_PIECES; i++) begin
      in_run = comp && (3'(i) >= best_start) && ({1'b0, 3'(i)} < run_end);
      if (pieces[i][15:12] != 4'd0) begin
        digits = 3'd4;
      end else if (pieces[i][11:8] != 4'd0) begin
        digits = 3'd3;
      end else if (pieces[i][7:4] != 4'd0) begin
        digits = 3'd2;
      end else begin
        digits = 3'd1;
      end
      push_desc.piece[i] = pieces[i];
      if (in_run) begin
        // Only the first piece of the run emits a colon, completing the double colon.
        push_desc.ndig[i] = 3'd0;
        push_desc.col[i]  = (3'(i) == best_start);
      end else begin
        push_desc.ndig[i] = digits;
        push_desc.col[i]  = (i != ipv6ts_pkg::NUM_PIECES - 1);
      end
      push_desc.busy[i] = (push_desc.ndig[i] != 3'd0) || push_desc.col[i];
    end
    push_desc.lead = comp && (best_start == 3'd0);
  end

  assign push_valid    = in_word.valid;
  assign in_word.ready = push_ready;

  `ASSERT_IMPLIES(a_front_nonempty, clk, rst_n, push_valid, push_desc.busy != '0)

endmodule

`default_nettype wire

### rtl/ipv6ts_queue.sv
// Two-entry queue of classified addresses between the front and back ends.
`default_nettype none
`include "assert_macros.svh"

module ipv6ts_queue (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  ipv6ts_pkg::desc_t wdata,
  input  wire logic         wvalid,
  output logic              wready,
  output ipv6ts_pkg::desc_t rdata,
  output logic              rvalid,
  input  wire logic         rpop
);

  ipv6ts_pkg::desc_t mem_r [ipv6ts_pkg::QDEPTH];
  logic [$clog2(ipv6ts_pkg::QDEPTH)-1:0] wptr_r, wptr_nxt;
  logic [$clog2(ipv6ts_pkg::QDEPTH)-1:0] rptr_r, rptr_nxt;
  logic [$clog2(ipv6ts_pkg::QDEPTH+1)-1:0] count_r, count_nxt;
  logic push;
  logic pop;

  assign wready = (count_r != ($clog2(ipv6ts_pkg::QDEPTH+1))'(ipv6ts_pkg::QDEPTH));
  assign rvalid = (count_r != '0);
  assign push   = wvalid && wready;
  assign pop    = rpop && rvalid;
  assign rdata  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = pop ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  `ASSERT_ALWAYS(a_queue_bound, clk, rst_n,
                 count_r <= ($clog2(ipv6ts_pkg::QDEPTH+1))'(ipv6ts_pkg::QDEPTH))

endmodule

`default_nettype wire

### rtl/ipv6ts_back.sv
// Back end: walks a classified address and emits one character per cycle while the output is ready.
`default_nettype none
`include "assert_macros.svh"

module ipv6ts_back (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  ipv6ts_pkg::desc_t head,
  input  wire logic         head_valid,
  output logic              head_pop,
  ipv6ts_out_if.source      out_word
);

  logic [2:0] cur_p_r, cur_p_nxt;
  logic [2:0] cur_c_r, cur_c_nxt;
  logic       lead_done_r, lead_done_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [ipv6ts_pkg::CHAR_W-1:0] out_char_r, out_char_nxt;
  logic       out_last_r, out_last_nxt;

  logic [ipv6ts_pkg::NUM_PIECES-1:0] above_mask;
  logic [ipv6ts_pkg::NUM_PIECES-1:0] later_mask;
  logic [2:0]  eff_p;
  logic [15:0] piece_val;
  logic [2:0]  nd;
  logic [2:0]  nchars;
  logic [1:0]  nib_sel;
  logic [3:0]  nibble;
  logic        lead_now;
  logic        piece_end;
  logic        last_now;
  logic        load;
  logic [ipv6ts_pkg::CHAR_W-1:0] char_now;

  // Pieces that still have characters, at or after the current one.
  assign above_mask = head.busy & ~((8'd1 << cur_p_r) - 8'd1);

  always_comb begin
    eff_p = 3'd0;
    for (int i = ipv6ts_pkg::NUM_PIECES - 1; i >= 0; i--) begin
      if (above_mask[i]) begin
        eff_p = 3'(i);
      end
    end
  end

  assign later_mask = head.busy & ~((8'd2 << eff_p) - 8'd1);
  assign piece_val  = head.piece[eff_p];
  assign nd         = head.ndig[eff_p];
  assign nchars     = nd + {2'b00, head.col[eff_p]};
  assign nib_sel    = 2'(nd - 3'd1 - cur_c_r);
  assign lead_now   = head.lead && !lead_done_r;
  assign piece_end  = (cur_c_r + 3'd1 == nchars);
  assign last_now   = !lead_now && piece_end && (later_mask == '0);
  assign load       = head_valid && (!out_valid_r || out_word.ready);
  assign head_pop   = load && last_now;

  always_comb begin
    unique case (nib_sel)
      2'd0:    nibble = piece_val[3:0];
      2'd1:    nibble = piece_val[7:4];
      2'd2:    nibble = piece_val[11:8];
      default: nibble = piece_val[15:12];
    endcase
  end

  always_comb begin
    if (lead_now || (cur_c_r >= nd)) begin
      char_now = ipv6ts_pkg::CHAR_COLON;
    end else begin
      char_now = ipv6ts_pkg::hex_char(nibble);
    end
  end

  always_comb begin
    cur_p_nxt     = cur_p_r;
    cur_c_nxt     = cur_c_r;
    lead_done_nxt = lead_done_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = char_now;
      out_last_nxt  = last_now;
      priority if (lead_now) begin
        lead_done_nxt = 1'b1;
      end else if (last_now) begin
        cur_p_nxt     = 3'd0;
        cur_c_nxt     = 3'd0;
        lead_done_nxt = 1'b0;
      end else if (piece_end) begin
        cur_p_nxt = eff_p + 3'd1;
        cur_c_nxt = 3'd0;
      end else begin
        cur_c_nxt = cur_c_r + 3'd1;
      end
    end else if (out_word.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_p_r     <= 3'd0;
      cur_c_r     <= 3'd0;
      lead_done_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_p_r     <= cur_p_nxt;
      cur_c_r     <= cur_c_nxt;
      lead_done_r <= lead_done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_word.valid     = out_valid_r;
  assign out_word.character = out_char_r;
  assign out_word.last      = out_last_r;

  `ASSERT_IMPLIES(a_back_piece_found, clk, rst_n, head_valid && !lead_now, above_mask != '0)
  `ASSERT_NEXT(a_back_last_flag, clk, rst_n, head_pop, out_valid_r && out_last_r)
  `ASSERT_IMPLIES(a_back_lead_fresh, clk, rst_n, head_valid && lead_now,
                  cur_p_r == 3'd0 && cur_c_r == 3'd0)

endmodule

`default_nettype wire
